// ===== rtl/image_first_difference_finder_defines.svh =====
// Assertion macros for the image first difference finder.
// Taken in by the top level; depends on nothing.
`ifndef IMAGE_FIRST_DIFFERENCE_FINDER_DEFINES_SVH
`define IMAGE_FIRST_DIFFERENCE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define IFDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ifdf assertion failed");

// Next-cycle implication, disabled while reset is low.
`define IFDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ifdf assertion failed");

`endif

// ===== rtl/ifdf_pkg.sv =====
// Package for the image first difference finder: sizes, depth and register codes.
// Used by the channel interfaces and the top level; depends on nothing.
package ifdf_pkg;

    localparam int WORD_BITS    = 64;
    localparam int MAX_ELEMENTS = 4096;
    localparam int MAX_LINES    = 4096;

    localparam int DATA_W    = 64;
    localparam int SIZE_W    = 13;
    localparam int DEPTH_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;
    localparam int POSX_W    = 19;
    localparam int POSY_W    = 13;

    localparam int COL_W     = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int LINE_W    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int BIT_IDX_W = $clog2(WORD_BITS);
    localparam int FOUNDX_W  = $clog2(MAX_ELEMENTS * WORD_BITS);

    localparam logic [DATA_W-1:0] WORD_MASK  = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);
    localparam logic [DATA_W-1:0] PIX8_MASK  = DATA_W'(64'h0000_0000_0000_00FF);
    localparam logic [DATA_W-1:0] PIX32_MASK = DATA_W'(64'h0000_0000_FFFF_FFFF);

    typedef enum logic [DEPTH_W-1:0] {
        DEPTH_BIN = 2'd0,
        DEPTH_8   = 2'd1,
        DEPTH_32  = 2'd2,
        DEPTH_BAD = 2'd3
    } t_depth;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_DEPTH  = 3'd0,
        REG_CMP_DEPTH  = 3'd1,
        REG_DEST_DEPTH = 3'd2,
        REG_ELEMS      = 3'd3,
        REG_LINES      = 3'd4
    } t_cfg_index;

endpackage

// ===== rtl/ifdf_pix_if.sv =====
// Input channel: one word of source, compare and destination elements.
// Depends on ifdf_pkg.
interface ifdf_pix_if;
    logic                          valid;
    logic                          ready;
    logic [ifdf_pkg::DATA_W-1:0]   src_value;
    logic [ifdf_pkg::DATA_W-1:0]   cmp_value;
    logic [ifdf_pkg::DATA_W-1:0]   dest_value;

    modport source (output valid, src_value, cmp_value, dest_value, input ready);
    modport sink   (input valid, src_value, cmp_value, dest_value, output ready);
endinterface

// ===== rtl/ifdf_res_if.sv =====
// Result channel: destination write and first-difference position per word.
// Depends on ifdf_pkg.
interface ifdf_res_if;
    logic                                valid;
    logic                                ready;
    logic                                write_dest;
    logic [ifdf_pkg::DATA_W-1:0]         dest_word;
    logic                                image_done;
    logic                                found;
    logic signed [ifdf_pkg::POSX_W-1:0]  pos_x;
    logic signed [ifdf_pkg::POSY_W-1:0]  pos_y;
    logic                                status;

    modport source (output valid, write_dest, dest_word, image_done, found, pos_x, pos_y,
                    status, input ready);
    modport sink   (input valid, write_dest, dest_word, image_done, found, pos_x, pos_y,
                    status, output ready);
endinterface

// ===== rtl/ifdf_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on ifdf_pkg.
interface ifdf_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ifdf_pkg::CFG_IDX_W-1:0]   index;
    logic [ifdf_pkg::CFG_DAT_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/image_first_difference_finder.sv =====
// Image first difference finder: compares raster-ordered source and compare words.
// Depends on ifdf_pkg, the three channel interfaces and the defines header.
//
// Usage:
//   i_pix carries one word per handshake: source, compare and current destination
//   element in raster order. o_res returns one word per input word: a destination
//   write flag and value for the first difference of the frame, the frame-end flag,
//   the position of the first difference so far (-1 if none or on a depth error) and the depth status.
//   i_cfg writes the depth and size registers; write them only while idle.
//   The result word is registered and valid in the cycle after its input word is accepted.
//   Throughput: one word per cycle while o_res is not stalled; the compare, lowest-bit
//   encode and position update sit between the input handshake and the result register.
//   Reset: synchronous, active low; registers return to 8-bit depth and a 1x1
//   frame, the position counters and the found flag clear. No clearing pass.
//   Stall: while o_res is stalled the result register holds and i_pix.ready
//   drops; it stays high when the result register is empty or being taken.
`include "image_first_difference_finder_defines.svh"

module image_first_difference_finder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ifdf_pix_if.sink    i_pix,
    ifdf_res_if.source  o_res,
    ifdf_cfg_if.sink    i_cfg
);

    localparam int SW = ifdf_pkg::SIZE_W;

    ifdf_pkg::t_depth                 r_src_depth;
    ifdf_pkg::t_depth                 r_cmp_depth;
    ifdf_pkg::t_depth                 r_dest_depth;
    logic [SW-1:0]                    r_elems;
    logic [SW-1:0]                    r_lines;

    logic [ifdf_pkg::COL_W-1:0]       r_col;
    logic [ifdf_pkg::LINE_W-1:0]      r_line;
    logic                             r_seen;
    logic [ifdf_pkg::FOUNDX_W-1:0]    r_found_x;
    logic [ifdf_pkg::LINE_W-1:0]      r_found_y;

    logic                             r_out_valid;
    logic                             r_write_dest;
    logic [ifdf_pkg::DATA_W-1:0]      r_dest_word;
    logic                             r_image_done;
    logic                             r_found;
    logic [ifdf_pkg::POSX_W-1:0]      r_pos_x;
    logic [ifdf_pkg::POSY_W-1:0]      r_pos_y;
    logic                             r_status;

    logic                             pix_acc;
    logic [SW-1:0]                    cols;
    logic [SW-1:0]                    lines;
    logic                             ok;
    logic                             last_col;
    logic                             last;
    logic [ifdf_pkg::DATA_W-1:0]      diff_bin;
    logic [ifdf_pkg::DATA_W-1:0]      iso_bit;
    logic [ifdf_pkg::BIT_IDX_W-1:0]   bit_idx;
    logic [ifdf_pkg::DATA_W-1:0]      pix_mask;
    logic                             write;
    logic [ifdf_pkg::DATA_W-1:0]      word;
    logic                             n_seen;
    logic [ifdf_pkg::FOUNDX_W-1:0]    n_found_x;
    logic [ifdf_pkg::LINE_W-1:0]      n_found_y;
    logic                             report;

    assign i_pix.ready = !r_out_valid || o_res.ready;
    assign pix_acc     = i_pix.valid && i_pix.ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_elems == '0) begin
            cols = SW'(1);
        end else if (r_elems > SW'(ifdf_pkg::MAX_ELEMENTS)) begin
            cols = SW'(ifdf_pkg::MAX_ELEMENTS);
        end else begin
            cols = r_elems;
        end
        if (r_lines == '0) begin
            lines = SW'(1);
        end else if (r_lines > SW'(ifdf_pkg::MAX_LINES)) begin
            lines = SW'(ifdf_pkg::MAX_LINES);
        end else begin
            lines = r_lines;
        end
    end

    assign ok       = (r_src_depth == r_cmp_depth) && (r_src_depth == r_dest_depth)
                      && (r_src_depth != ifdf_pkg::DEPTH_BAD);
    assign last_col = (SW'(r_col) + SW'(1)) >= cols;
    assign last     = last_col && ((SW'(r_line) + SW'(1)) >= lines);

    // Isolate the lowest differing bit, then encode its index.
    assign diff_bin = (i_pix.src_value ^ i_pix.cmp_value) & ifdf_pkg::WORD_MASK;
    assign iso_bit  = diff_bin & (~diff_bin + ifdf_pkg::DATA_W'(1));

    always_comb begin
        bit_idx = '0;
        for (int i = 0; i < ifdf_pkg::WORD_BITS; i++) begin
            if (iso_bit[i]) begin
                bit_idx = bit_idx | ifdf_pkg::BIT_IDX_W'(i);
            end
        end
    end

    assign pix_mask = (r_src_depth == ifdf_pkg::DEPTH_8) ? ifdf_pkg::PIX8_MASK
                                                         : ifdf_pkg::PIX32_MASK;

    always_comb begin
        write     = 1'b0;
        word      = '0;
        n_found_x = r_found_x;
        if (ok && !r_seen) begin
            if (r_src_depth == ifdf_pkg::DEPTH_BIN) begin
                if (diff_bin != '0) begin
                    write     = 1'b1;
                    word      = (i_pix.dest_value & ifdf_pkg::WORD_MASK) | iso_bit;
                    n_found_x = ifdf_pkg::FOUNDX_W'(r_col)
                                * ifdf_pkg::FOUNDX_W'(ifdf_pkg::WORD_BITS)
                                + ifdf_pkg::FOUNDX_W'(bit_idx);
                end
            end else if ((i_pix.src_value & pix_mask) != (i_pix.cmp_value & pix_mask)) begin
                write     = 1'b1;
                word      = i_pix.src_value & pix_mask;
                n_found_x = ifdf_pkg::FOUNDX_W'(r_col);
            end
        end
        n_seen    = r_seen || write;
        n_found_y = write ? r_line : r_found_y;
        report    = ok && n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_depth  <= ifdf_pkg::DEPTH_8;
            r_cmp_depth  <= ifdf_pkg::DEPTH_8;
            r_dest_depth <= ifdf_pkg::DEPTH_8;
            r_elems      <= SW'(1);
            r_lines      <= SW'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (ifdf_pkg::t_cfg_index'(i_cfg.index))
                ifdf_pkg::REG_SRC_DEPTH:  r_src_depth  <=
                    ifdf_pkg::t_depth'(i_cfg.data[ifdf_pkg::DEPTH_W-1:0]);
                ifdf_pkg::REG_CMP_DEPTH:  r_cmp_depth  <=
                    ifdf_pkg::t_depth'(i_cfg.data[ifdf_pkg::DEPTH_W-1:0]);
                ifdf_pkg::REG_DEST_DEPTH: r_dest_depth <=
                    ifdf_pkg::t_depth'(i_cfg.data[ifdf_pkg::DEPTH_W-1:0]);
                ifdf_pkg::REG_ELEMS:      r_elems      <= i_cfg.data[SW-1:0];
                ifdf_pkg::REG_LINES:      r_lines      <= i_cfg.data[SW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_line    <= '0;
            r_seen    <= 1'b0;
            r_found_x <= '0;
            r_found_y <= '0;
        end else if (pix_acc) begin
            if (last) begin
                r_col     <= '0;
                r_line    <= '0;
                r_seen    <= 1'b0;
                r_found_x <= '0;
                r_found_y <= '0;
            end else begin
                if (last_col) begin
                    r_col  <= '0;
                    r_line <= r_line + ifdf_pkg::LINE_W'(1);
                end else begin
                    r_col  <= r_col + ifdf_pkg::COL_W'(1);
                end
                r_seen    <= n_seen;
                r_found_x <= n_found_x;
                r_found_y <= n_found_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pix_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_write_dest <= write;
            r_dest_word  <= word;
            r_image_done <= last;
            r_found      <= report;
            r_pos_x      <= report ? ifdf_pkg::POSX_W'(n_found_x) : '1;
            r_pos_y      <= report ? ifdf_pkg::POSY_W'(n_found_y) : '1;
            r_status     <= !ok;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.write_dest = r_write_dest;
    assign o_res.dest_word  = r_dest_word;
    assign o_res.image_done = r_image_done;
    assign o_res.found      = r_found;
    assign o_res.pos_x      = r_pos_x;
    assign o_res.pos_y      = r_pos_y;
    assign o_res.status     = r_status;

    `IFDF_ASSERT_NOW(a_err_no_write, i_clk, i_rst_n, r_out_valid && r_status,
        !r_found && !r_write_dest && (r_pos_x == '1) && (r_pos_y == '1))
    `IFDF_ASSERT_NOW(a_write_found, i_clk, i_rst_n, r_out_valid && r_write_dest,
        r_found && !r_status)
    `IFDF_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, pix_acc && last,
        (r_col == '0) && (r_line == '0) && !r_seen && r_out_valid && r_image_done)
    `IFDF_ASSERT_NEXT(a_single_write, i_clk, i_rst_n, pix_acc && r_seen,
        !r_write_dest)

endmodule
